### rtl/virtual_channel_flit_buffer_defines.svh
// -----------------------------------------------------------------------------
// Virtual channel flit buffer assertion macros
// Shared concurrent check forms, clocked on clk_i, quiet during reset.
// -----------------------------------------------------------------------------
`ifndef VIRTUAL_CHANNEL_FLIT_BUFFER_DEFINES_SVH
`define VIRTUAL_CHANNEL_FLIT_BUFFER_DEFINES_SVH

// same-cycle implication
`define VCFB_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vcfb: same-cycle check failed");

// next-cycle implication
`define VCFB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vcfb: next-cycle check failed");

`endif

### rtl/vcfb_pkg.sv
// -----------------------------------------------------------------------------
// Virtual channel flit buffer package
// Sizes, codes and the controller command bundle.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vcfb_pkg;

  localparam int unsigned MAX_CHANNELS = 8;
  localparam int unsigned MAX_DEPTH    = 16;
  localparam int unsigned FLIT_W       = 64;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CH_W       = 3;
  localparam int unsigned PTR_W      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_DEPTH + 1);
  localparam int unsigned ADDR_W     = CH_W + PTR_W;
  localparam int unsigned MEM_DEPTH  = MAX_CHANNELS * MAX_DEPTH;
  localparam int unsigned STATUS_W   = 2;

  localparam int unsigned ACT_W      = 4;
  localparam int unsigned LIM_W      = 5;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned CFG_IDX_W  = 1;

  typedef enum logic [CMD_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_PULL  = 2'd1,
    OP_PEEK  = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BADCH = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_CHANNELS   = 1'b0,
    REG_QUEUE_DEPTH_LIMIT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load_out;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

### rtl/vcfb_if.sv
// -----------------------------------------------------------------------------
// Virtual channel flit buffer channel interfaces
// Request and response valid/ready channels with their payloads.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface vcfb_req_if;
  logic                           valid;
  logic                           ready;
  logic [vcfb_pkg::CMD_W-1:0]     cmd;
  logic [vcfb_pkg::CH_W-1:0]      channel;
  logic [vcfb_pkg::FLIT_W-1:0]    flit_in;

  modport source (output valid, cmd, channel, flit_in, input ready);
  modport sink   (input valid, cmd, channel, flit_in, output ready);
endinterface

interface vcfb_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [vcfb_pkg::FLIT_W-1:0]    flit_out;
  logic [vcfb_pkg::STATUS_W-1:0]  status;
  logic [vcfb_pkg::CNT_W-1:0]     occupancy;
  logic                           channel_empty;
  logic                           channel_full;

  modport source (output valid, flit_out, status, occupancy, channel_empty, channel_full,
                  input ready);
  modport sink   (input valid, flit_out, status, occupancy, channel_empty, channel_full,
                  output ready);
endinterface

`default_nettype wire

### rtl/vcfb_ctrl.sv
// -----------------------------------------------------------------------------
// Virtual channel flit buffer controller
// Sequences capture, execute and result load; owns the result valid flag.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "virtual_channel_flit_buffer_defines.svh"

module vcfb_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output vcfb_pkg::ctrl_cmd_t        cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free       = !out_valid_q || out_ready_i;
  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign cmd_o.capture   = in_valid_i && in_ready_o;
  assign cmd_o.exec      = (state_q == S_EXEC);
  assign cmd_o.load_out  = (state_q == S_FIN) && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
          if (in_valid_i) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `VCFB_ASSERT_NEXT(a_capture_to_exec, cmd_o.capture, state_q == S_EXEC)
  `VCFB_ASSERT(a_busy_not_ready, state_q != S_IDLE, !in_ready_o)
  `VCFB_ASSERT_NEXT(a_load_sets_valid, cmd_o.load_out, out_valid_q && state_q == S_IDLE)

endmodule

`default_nettype wire

### rtl/vcfb_datapath.sv
// -----------------------------------------------------------------------------
// Virtual channel flit buffer datapath
// Config registers, per-channel pointers and counts, flit memory, result regs.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "virtual_channel_flit_buffer_defines.svh"

module vcfb_datapath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  vcfb_pkg::ctrl_cmd_t                     cmd_i,
  input  wire logic                               cfg_we_i,
  input  wire logic [vcfb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [vcfb_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic [vcfb_pkg::CMD_W-1:0]         op_i,
  input  wire logic [vcfb_pkg::CH_W-1:0]          channel_i,
  input  wire logic [vcfb_pkg::FLIT_W-1:0]        flit_i,
  output logic [vcfb_pkg::FLIT_W-1:0]             flit_out_o,
  output logic [vcfb_pkg::STATUS_W-1:0]           status_o,
  output logic [vcfb_pkg::CNT_W-1:0]              occupancy_o,
  output logic                                    channel_empty_o,
  output logic                                    channel_full_o
);

  localparam int unsigned MaxCh  = vcfb_pkg::MAX_CHANNELS;
  localparam int unsigned MaxDep = vcfb_pkg::MAX_DEPTH;

  // config
  logic [vcfb_pkg::ACT_W-1:0] active_q;
  logic [vcfb_pkg::LIM_W-1:0] limit_q;

  // captured beat
  vcfb_pkg::op_e               op_q;
  logic [vcfb_pkg::CH_W-1:0]   ch_q;
  logic [vcfb_pkg::FLIT_W-1:0] flit_q;

  // per-channel queue state
  logic [vcfb_pkg::PTR_W-1:0] head_q  [MaxCh];
  logic [vcfb_pkg::PTR_W-1:0] tail_q  [MaxCh];
  logic [vcfb_pkg::CNT_W-1:0] count_q [MaxCh];

  logic [vcfb_pkg::FLIT_W-1:0] mem_q [vcfb_pkg::MEM_DEPTH];
  logic [vcfb_pkg::FLIT_W-1:0] rdata_q;

  vcfb_pkg::status_e          res_status_q;
  logic [vcfb_pkg::CNT_W-1:0] res_occ_q;
  logic                       res_empty_q;
  logic                       res_full_q;
  logic                       res_rd_q;

  logic [vcfb_pkg::FLIT_W-1:0]   flit_out_q;
  logic [vcfb_pkg::STATUS_W-1:0] status_out_q;
  logic [vcfb_pkg::CNT_W-1:0]    occ_out_q;
  logic                          empty_out_q;
  logic                          full_out_q;

  logic [vcfb_pkg::ACT_W-1:0]  eff_ch;
  logic [vcfb_pkg::CNT_W-1:0]  eff_depth;
  logic                        bad_ch;
  logic [vcfb_pkg::CNT_W-1:0]  cur_cnt;
  logic [vcfb_pkg::PTR_W-1:0]  cur_head;
  logic [vcfb_pkg::PTR_W-1:0]  cur_tail;
  logic [vcfb_pkg::PTR_W-1:0]  head_nxt;
  logic [vcfb_pkg::PTR_W-1:0]  tail_nxt;
  logic                        push_ok;
  logic                        pull_ok;
  logic                        rd_en;
  vcfb_pkg::status_e           status_c;
  logic [vcfb_pkg::CNT_W-1:0]  new_cnt;
  logic [vcfb_pkg::ADDR_W-1:0] wr_addr;
  logic [vcfb_pkg::ADDR_W-1:0] rd_addr;

  // clamp config
  always_comb begin
    if (active_q == '0) begin
      eff_ch = vcfb_pkg::ACT_W'(1);
    end else if (active_q > vcfb_pkg::ACT_W'(MaxCh)) begin
      eff_ch = vcfb_pkg::ACT_W'(MaxCh);
    end else begin
      eff_ch = active_q;
    end
    if (limit_q == '0) begin
      eff_depth = vcfb_pkg::CNT_W'(1);
    end else if (vcfb_pkg::CNT_W'(limit_q) > vcfb_pkg::CNT_W'(MaxDep)) begin
      eff_depth = vcfb_pkg::CNT_W'(MaxDep);
    end else begin
      eff_depth = vcfb_pkg::CNT_W'(limit_q);
    end
  end

  assign bad_ch   = vcfb_pkg::ACT_W'(ch_q) >= eff_ch;
  assign cur_cnt  = count_q[ch_q];
  assign cur_head = head_q[ch_q];
  assign cur_tail = tail_q[ch_q];
  assign head_nxt = (cur_head == vcfb_pkg::PTR_W'(MaxDep - 1)) ? '0 : cur_head + 1'b1;
  assign tail_nxt = (cur_tail == vcfb_pkg::PTR_W'(MaxDep - 1)) ? '0 : cur_tail + 1'b1;
  assign wr_addr  = {ch_q, cur_tail};
  assign rd_addr  = {ch_q, cur_head};

  always_comb begin
    push_ok  = 1'b0;
    pull_ok  = 1'b0;
    rd_en    = 1'b0;
    status_c = vcfb_pkg::ST_OK;
    unique case (op_q)
      vcfb_pkg::OP_PUSH: begin
        if (cur_cnt >= eff_depth) status_c = vcfb_pkg::ST_FULL;
        else                      push_ok  = 1'b1;
      end
      vcfb_pkg::OP_PULL: begin
        if (cur_cnt == '0) begin
          status_c = vcfb_pkg::ST_EMPTY;
        end else begin
          pull_ok = 1'b1;
          rd_en   = 1'b1;
        end
      end
      vcfb_pkg::OP_PEEK: begin
        if (cur_cnt == '0) status_c = vcfb_pkg::ST_EMPTY;
        else               rd_en    = 1'b1;
      end
      vcfb_pkg::OP_QUERY: status_c = vcfb_pkg::ST_OK;
      default:            status_c = vcfb_pkg::ST_OK;
    endcase
    if (bad_ch) begin
      push_ok  = 1'b0;
      pull_ok  = 1'b0;
      rd_en    = 1'b0;
      status_c = vcfb_pkg::ST_BADCH;
    end
  end

  always_comb begin
    if (push_ok)      new_cnt = cur_cnt + 1'b1;
    else if (pull_ok) new_cnt = cur_cnt - 1'b1;
    else              new_cnt = cur_cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= vcfb_pkg::ACT_W'(MaxCh);
      limit_q  <= vcfb_pkg::LIM_W'(MaxDep);
    end else if (cfg_we_i) begin
      unique case (vcfb_pkg::reg_idx_e'(cfg_idx_i))
        vcfb_pkg::REG_ACTIVE_CHANNELS:   active_q <= cfg_data_i[vcfb_pkg::ACT_W-1:0];
        vcfb_pkg::REG_QUEUE_DEPTH_LIMIT: limit_q  <= cfg_data_i[vcfb_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxCh; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else if (cmd_i.exec) begin
      if (push_ok) tail_q[ch_q] <= tail_nxt;
      if (pull_ok) head_q[ch_q] <= head_nxt;
      count_q[ch_q] <= new_cnt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= vcfb_pkg::op_e'(op_i);
      ch_q   <= channel_i;
      flit_q <= flit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && push_ok) mem_q[wr_addr] <= flit_q;
    if (cmd_i.exec && rd_en)   rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_status_q <= status_c;
      res_occ_q    <= bad_ch ? '0 : new_cnt;
      res_empty_q  <= !bad_ch && (new_cnt == '0);
      res_full_q   <= !bad_ch && (new_cnt >= eff_depth);
      res_rd_q     <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      flit_out_q   <= res_rd_q ? rdata_q : '0;
      status_out_q <= res_status_q;
      occ_out_q    <= res_occ_q;
      empty_out_q  <= res_empty_q;
      full_out_q   <= res_full_q;
    end
  end

  assign flit_out_o      = flit_out_q;
  assign status_o        = status_out_q;
  assign occupancy_o     = occ_out_q;
  assign channel_empty_o = empty_out_q;
  assign channel_full_o  = full_out_q;

  `VCFB_ASSERT(a_count_bound, cmd_i.exec, cur_cnt <= vcfb_pkg::CNT_W'(MaxDep))
  `VCFB_ASSERT(a_ptr_consistent, cmd_i.exec,
               vcfb_pkg::PTR_W'(cur_head + cur_cnt) == cur_tail)
  `VCFB_ASSERT_NEXT(a_empty_matches_occ, cmd_i.exec,
                    res_empty_q == ((res_occ_q == '0) && (res_status_q != vcfb_pkg::ST_BADCH)))

endmodule

`default_nettype wire

### rtl/virtual_channel_flit_buffer.sv
// The controller takes a new beat only after the previous one has passed through
// its sequence (capture, queue update with flit memory access, result load); the
// result load waits while an earlier response beat is still held by the sink.
// Reset clears per-channel pointers and counts and sets the config to 8
// channels and depth 16; the flit memory is not cleared.
// -----------------------------------------------------------------------------
// Virtual channel flit buffer top level
// Per-channel flit FIFOs with push, pull, peek and status query commands.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module virtual_channel_flit_buffer (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [vcfb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [vcfb_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  vcfb_req_if.sink                               req_i,
  vcfb_rsp_if.source                             rsp_o
);

  vcfb_pkg::ctrl_cmd_t ctrl_cmd;

  vcfb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (ctrl_cmd)
  );

  vcfb_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctrl_cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .op_i            (req_i.cmd),
    .channel_i       (req_i.channel),
    .flit_i          (req_i.flit_in),
    .flit_out_o      (rsp_o.flit_out),
    .status_o        (rsp_o.status),
    .occupancy_o     (rsp_o.occupancy),
    .channel_empty_o (rsp_o.channel_empty),
    .channel_full_o  (rsp_o.channel_full)
  );

endmodule

`default_nettype wire

### dv/virtual_channel_flit_buffer_tb.sv
// -----------------------------------------------------------------------------
// Virtual channel flit buffer testbench
// Drives push, pull, peek and status-query beats over the request channel and
// checks every response beat against a cycle-free model of the per-channel
// flit queues or against a fixed expected beat from a short directed table that
// covers empty, full, bad-channel and clamped-register cases. Randomized phases
// follow under changing channel and depth settings and changing idle and stall patterns.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module virtual_channel_flit_buffer_tb;
  import vcfb_pkg::*;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 11;
  localparam int TIMEOUT_CYCLES  = 200000;
  localparam int HOLD_CYCLES     = 300;
  localparam int PHASES          = 8;
  localparam int BEATS_PER_PHASE = 205;
  localparam int NDIR            = 31;
  localparam int MAX_PRINTS      = 40;

  typedef struct packed {
    logic [FLIT_W-1:0] flit;
    status_e           status;
    logic [CNT_W-1:0]  occ;
    logic              empty;
    logic              full;
  } rsp_beat_t;

  typedef enum logic {
    ROW_BEAT = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    op_e                   op;
    logic [CH_W-1:0]       ch;
    logic [FLIT_W-1:0]     flit;
    reg_idx_e              ridx;
    logic [CFG_DATA_W-1:0] rval;
    logic                  typed;
    rsp_beat_t             want;
  } dir_row_t;

  localparam rsp_beat_t NO_RSP     = '0;
  localparam rsp_beat_t EMPTY_RD   = '{64'h0, ST_EMPTY, 5'd0, 1'b1, 1'b0};
  localparam rsp_beat_t IDLE_QUERY = '{64'h0, ST_OK, 5'd0, 1'b1, 1'b0};
  localparam rsp_beat_t BAD_CH     = '{64'h0, ST_BADCH, 5'd0, 1'b0, 1'b0};

  localparam dir_row_t DIR_ROWS [NDIR] = '{
    '{ROW_BEAT, OP_PULL,  3'd0, 64'h0, REG_ACTIVE_CHANNELS, 5'd0, 1'b1, EMPTY_RD},
    '{ROW_BEAT, OP_PEEK,  3'd7, 64'h0, REG_ACTIVE_CHANNELS, 5'd0, 1'b1, EMPTY_RD},
    '{ROW_BEAT, OP_QUERY, 3'd3, 64'h0, REG_ACTIVE_CHANNELS, 5'd0, 1'b1, IDLE_QUERY},
    '{ROW_BEAT, OP_PUSH,  3'd0, '1,    REG_ACTIVE_CHANNELS, 5'd0, 1'b0, NO_RSP},
    '{ROW_BEAT, OP_PUSH,  3'd0, 64'h0, REG_ACTIVE_CHANNELS, 5'd0, 1'b0, NO_RSP},
    '{ROW_BEAT, OP_PEEK,  3'd0, 64'h0, REG_ACTIVE_CHANNELS, 5'd0, 1'b0, NO_RSP},
    '{ROW_BEAT, OP_PULL,  3'd0, 64'h0, REG_ACTIVE_CHANNELS, 5'd0, 1'b0, NO_RSP},
    '{ROW_BEAT, OP_PULL,  3'd0, 64'h0, REG_ACTIVE_CHANNELS, 5'd0, 1'b0, NO_RSP},
    '{ROW_BEAT, OP_PUSH,  3'd7, 64'h5555_5555_5555_5555,
      REG_ACTIVE_CHANNELS, 5'd0, 1'b0, NO_RSP},
    '{ROW_BEAT, OP_PUSH,  3'd7, 64'hAAAA_AAAA_AAAA_AAAA,
      REG_ACTIVE_CHANNELS, 5'd0, 1'b0, NO_RSP},
    '{ROW_BEAT, OP_PUSH,  3'd7, 64'h0123_4567_89AB_CDEF,
      REG_ACTIVE_CHANNELS, 5'd0, 1'b0, NO_RSP},
    // limit drops below occupancy: channel 7 reads as full
    '{ROW_CFG,  OP_QUERY, 3'd0, 64'h0, REG_QUEUE_DEPTH_LIMIT, 5'd1, 1'b0, NO_RSP},
    '{ROW_BEAT, OP_QUERY, 3'd7, 64'h0, REG_ACTIVE_CHANNELS, 5'd0, 1'b0, NO_RSP},
    '{ROW_BEAT, OP_PUSH,  3'd7, 64'hDEAD_BEEF_0000_0001,
      REG_ACTIVE_CHANNELS, 5'd0, 1'b0, NO_RSP},
    '{ROW_BEAT, OP_PULL,  3'd7, 64'h0, REG_ACTIVE_CHANNELS, 5'd0, 1'b0, NO_RSP},
    '{ROW_CFG,  OP_QUERY, 3'd0, 64'h0, REG_ACTIVE_CHANNELS, 5'd1, 1'b0, NO_RSP},
    '{ROW_BEAT, OP_PUSH,  3'd7, 64'h1, REG_ACTIVE_CHANNELS, 5'd0, 1'b1, BAD_CH},
    '{ROW_BEAT, OP_PEEK,  3'd1, 64'h0, REG_ACTIVE_CHANNELS, 5'd0, 1'b1, BAD_CH},
    '{ROW_BEAT, OP_PUSH,  3'd0, 64'h8000_0000_0000_0000,
      REG_ACTIVE_CHANNELS, 5'd0, 1'b0, NO_RSP},
    '{ROW_BEAT, OP_PUSH,  3'd0, 64'h7FFF_FFFF_FFFF_FFFF,
      REG_ACTIVE_CHANNELS, 5'd0, 1'b0, NO_RSP},
    // zero channels clamps to one
    '{ROW_CFG,  OP_QUERY, 3'd0, 64'h0, REG_ACTIVE_CHANNELS, 5'd0, 1'b0, NO_RSP},
    '{ROW_BEAT, OP_QUERY, 3'd1, 64'h0, REG_ACTIVE_CHANNELS, 5'd0, 1'b1, BAD_CH},
    '{ROW_BEAT, OP_PULL,  3'd0, 64'h0, REG_ACTIVE_CHANNELS, 5'd0, 1'b0, NO_RSP},
    // oversized settings clamp to the maxima, zero depth to one
    '{ROW_CFG,  OP_QUERY, 3'd0, 64'h0, REG_ACTIVE_CHANNELS, 5'd15, 1'b0, NO_RSP},
    '{ROW_CFG,  OP_QUERY, 3'd0, 64'h0, REG_QUEUE_DEPTH_LIMIT, 5'd0, 1'b0, NO_RSP},
    '{ROW_BEAT, OP_PUSH,  3'd3, 64'hFFFF_0000_FFFF_0000,
      REG_ACTIVE_CHANNELS, 5'd0, 1'b0, NO_RSP},
    '{ROW_BEAT, OP_PUSH,  3'd3, 64'h2, REG_ACTIVE_CHANNELS, 5'd0, 1'b0, NO_RSP},
    '{ROW_CFG,  OP_QUERY, 3'd0, 64'h0, REG_QUEUE_DEPTH_LIMIT, 5'd31, 1'b0, NO_RSP},
    // deactivated channel 7 kept its flits
    '{ROW_BEAT, OP_PULL,  3'd7, 64'h0, REG_ACTIVE_CHANNELS, 5'd0, 1'b0, NO_RSP},
    '{ROW_BEAT, OP_PULL,  3'd7, 64'h0, REG_ACTIVE_CHANNELS, 5'd0, 1'b0, NO_RSP},
    '{ROW_BEAT, OP_PULL,  3'd3, 64'h0, REG_ACTIVE_CHANNELS, 5'd0, 1'b0, NO_RSP}
  };

  localparam logic [CFG_DATA_W-1:0] ACT_PLAN   [PHASES] = '{8, 1, 3, 8, 2, 5, 1, 8};
  localparam logic [CFG_DATA_W-1:0] DEPTH_PLAN [PHASES] = '{16, 1, 9, 2, 16, 6, 16, 4};

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  vcfb_req_if req_bus ();
  vcfb_rsp_if rsp_bus ();

  virtual_channel_flit_buffer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // queue model
  logic [FLIT_W-1:0] slot_mem [MAX_CHANNELS][MAX_DEPTH];
  logic [PTR_W-1:0]  rd_ptr   [MAX_CHANNELS];
  logic [PTR_W-1:0]  wr_ptr   [MAX_CHANNELS];
  logic [CNT_W-1:0]  fill     [MAX_CHANNELS];
  logic [ACT_W-1:0]  act_reg;
  logic [LIM_W-1:0]  lim_reg;

  rsp_beat_t pending_results [$];
  int        err_count;
  int        beats_sent;
  int        cfg_writes;
  int        status_hits [4];
  int        send_pct;
  int        recv_pct;
  int        hold_token;
  int        hold_seen;
  int        hold_left;

  function automatic int unsigned eff_lanes();
    if (act_reg < 1) return 1;
    if (act_reg > MAX_CHANNELS) return MAX_CHANNELS;
    return act_reg;
  endfunction

  function automatic rsp_beat_t predict_flit_rsp(op_e op, logic [CH_W-1:0] ch,
                                                 logic [FLIT_W-1:0] flit);
    rsp_beat_t   r;
    int unsigned depth;
    r = '0;
    r.status = ST_OK;
    depth = (lim_reg < 1) ? 1 : (lim_reg > MAX_DEPTH) ? MAX_DEPTH : lim_reg;
    if (ch >= eff_lanes()) begin
      r.status = ST_BADCH;
      return r;
    end
    case (op)
      OP_PUSH: begin
        if (fill[ch] >= depth) begin
          r.status = ST_FULL;
        end else begin
          slot_mem[ch][wr_ptr[ch]] = flit;
          wr_ptr[ch] = wr_ptr[ch] + 1'b1;
          fill[ch] = fill[ch] + 1'b1;
        end
      end
      OP_PULL, OP_PEEK: begin
        if (fill[ch] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.flit = slot_mem[ch][rd_ptr[ch]];
          if (op == OP_PULL) begin
            rd_ptr[ch] = rd_ptr[ch] + 1'b1;
            fill[ch] = fill[ch] - 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.occ   = fill[ch];
    r.empty = (fill[ch] == 0);
    r.full  = (fill[ch] >= depth);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_result();
    rsp_beat_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("response beat with nothing pending");
    end else begin
      want = pending_results[0];
      pending_results.delete(0);
      if (rsp_bus.flit_out !== want.flit)
        report_mismatch($sformatf("flit_out %h, want %h", rsp_bus.flit_out, want.flit));
      if (rsp_bus.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", rsp_bus.status, want.status));
      if (rsp_bus.occupancy !== want.occ)
        report_mismatch($sformatf("occupancy %0d, want %0d", rsp_bus.occupancy, want.occ));
      if (rsp_bus.channel_empty !== want.empty)
        report_mismatch($sformatf("channel_empty %b, want %b",
                                  rsp_bus.channel_empty, want.empty));
      if (rsp_bus.channel_full !== want.full)
        report_mismatch($sformatf("channel_full %b, want %b",
                                  rsp_bus.channel_full, want.full));
    end
  endtask

  // response side: checking, random stalls, long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) check_result();
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_bus.ready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_pct);
    end
  end

  // entered and left in the time step of a rising edge
  task automatic send_beat(op_e op, logic [CH_W-1:0] ch, logic [FLIT_W-1:0] flit,
                           logic typed, rsp_beat_t want);
    rsp_beat_t pred;
    while ($urandom_range(0, 99) < send_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid   <= 1'b1;
    req_bus.cmd     <= op;
    req_bus.channel <= ch;
    req_bus.flit_in <= flit;
    do @(posedge clk_i); while (!req_bus.ready);
    pred = predict_flit_rsp(op, ch, flit);
    status_hits[pred.status]++;
    pending_results.insert(pending_results.size(), typed ? want : pred);
    beats_sent++;
  endtask

  task automatic hold_until_drained();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    hold_until_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_ACTIVE_CHANNELS) act_reg = val[ACT_W-1:0];
    else lim_reg = val[LIM_W-1:0];
    cfg_writes++;
  endtask

  initial begin
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("FAIL virtual_channel_flit_buffer");
    $finish;
  end

  initial begin
    int                ph;
    int                k;
    int                push_pct;
    int                guard;
    op_e               op;
    logic [CH_W-1:0]   ch;
    logic [CH_W-1:0]   focus;
    logic [FLIT_W-1:0] flit;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_ACTIVE_CHANNELS;
    cfg_data_i      = '0;
    req_bus.valid   = 1'b0;
    req_bus.cmd     = OP_QUERY;
    req_bus.channel = '0;
    req_bus.flit_in = '0;
    rsp_bus.ready   = 1'b0;
    err_count  = 0;
    beats_sent = 0;
    cfg_writes = 0;
    status_hits = '{default: 0};
    send_pct   = 0;
    recv_pct   = 0;
    hold_token = 0;
    hold_seen  = 0;
    hold_left  = 0;
    focus      = '0;
    act_reg    = 4'd8;
    lim_reg    = 5'd16;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      rd_ptr[c] = '0;
      wr_ptr[c] = '0;
      fill[c]   = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NDIR; i++) begin
      if (DIR_ROWS[i].kind == ROW_CFG)
        write_reg(DIR_ROWS[i].ridx, DIR_ROWS[i].rval);
      else
        send_beat(DIR_ROWS[i].op, DIR_ROWS[i].ch, DIR_ROWS[i].flit,
                  DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph < 6) begin
        write_reg(REG_ACTIVE_CHANNELS, ACT_PLAN[ph]);
        write_reg(REG_QUEUE_DEPTH_LIMIT, DEPTH_PLAN[ph]);
      end else begin
        write_reg(REG_ACTIVE_CHANNELS, $urandom_range(1, MAX_CHANNELS));
        write_reg(REG_QUEUE_DEPTH_LIMIT, $urandom_range(1, MAX_DEPTH));
      end
      case (ph % 4)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 81; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 81; end
        default: begin send_pct = 18; recv_pct = 18; end
      endcase
      for (k = 0; k < BEATS_PER_PHASE; k++) begin
        // alternate fill and drain windows, mostly on one channel
        if (k % 80 == 0) focus = $urandom_range(0, eff_lanes() - 1);
        push_pct = ((k / 40) % 2 == 0) ? 85 : 20;
        if ($urandom_range(0, 9) == 0) ch = $urandom_range(0, MAX_CHANNELS - 1);
        else if ($urandom_range(0, 9) < 7) ch = focus;
        else ch = $urandom_range(0, eff_lanes() - 1);
        if ($urandom_range(0, 99) < push_pct) begin
          op = OP_PUSH;
        end else begin
          case ($urandom_range(0, 5))
            0, 1, 2: op = OP_PULL;
            3, 4:    op = OP_PEEK;
            default: op = OP_QUERY;
          endcase
        end
        case ($urandom_range(0, 15))
          0:       flit = '1;
          1:       flit = '0;
          default: flit = {$urandom, $urandom};
        endcase
        if (ph == 0 && k == 60) hold_token++;
        if (ph == 0 && k == 150) hold_until_drained();
        send_beat(op, ch, flit, 1'b0, NO_RSP);
      end
    end

    req_bus.valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", pending_results.size()));

    $display("Ran %0d beats across %0d register writes, idle and stall mixes, long hold-off.",
             beats_sent, cfg_writes);
    $display("Status mix ok/full/empty/bad-channel: %0d/%0d/%0d/%0d, mismatches: %0d",
             status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
             status_hits[ST_BADCH], err_count);
    if (err_count == 0)
      $display("PASS virtual_channel_flit_buffer");
    else
      $display("FAIL virtual_channel_flit_buffer");
    $finish;
  end

endmodule
